### rtl/core/btlv_pkg.sv
// Shared types, codes and the tag lookup for the BER TLV header parser.
// No dependencies; every other file in rtl/core imports this package.
package btlv_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LENGTH_BYTES_DEF = 8;
    localparam int AVAIL_WIDTH_DEF      = 32;

    // Field widths fixed by the stream format
    localparam int BYTE_W   = 8;
    localparam int AVAIL_IN_W = 32;
    localparam int LEN_W    = 64;
    localparam int HSIZE_W  = 8;

    // Length byte markers
    localparam logic [BYTE_W-1:0] LEN_INDEFINITE = 8'h80;

    // Tag classes
    localparam logic [1:0] CLS_CONTEXT = 2'd2;

    // Known-tag codes
    typedef enum logic [3:0] {
        KT_UNKNOWN   = 4'd0,
        KT_INTEGER   = 4'd1,
        KT_BITSTRING = 4'd2,
        KT_OCTETSTR  = 4'd3,
        KT_NULL      = 4'd4,
        KT_OID       = 4'd5,
        KT_ENUM      = 4'd6,
        KT_UTF8      = 4'd7,
        KT_SEQUENCE  = 4'd8,
        KT_SET       = 4'd9,
        KT_NUMERIC   = 4'd10,
        KT_PRINTABLE = 4'd11,
        KT_IA5       = 4'd12,
        KT_UTCTIME   = 4'd13,
        KT_GENTIME   = 4'd14
    } known_tag_t;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_EXCEEDS  = 3'd3,
        ST_LEN_LONG = 3'd4
    } status_t;

    // Decoder phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LEN  = 3'b010,
        PH_LONG = 3'b100
    } phase_t;

    // Request from the header sequencer to the result builder
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] tag_byte;
        logic              indef;
        logic [LEN_W-1:0]  len;
        logic [HSIZE_W-1:0] hsize;
        status_t           forced;
    } emit_req_t;

    // One result beat; packed so that tag_class lands in the lowest bits
    typedef struct packed {
        status_t            status;
        logic [HSIZE_W-1:0] header_size;
        logic [LEN_W-1:0]   body_len;
        logic               indefinite;
        known_tag_t         known_tag;
        logic [4:0]         tag_number;
        logic               is_constructed;
        logic [1:0]         tag_class;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Map a universal tag number to its known-tag code
    function automatic known_tag_t known_map(input logic [4:0] num);
        known_tag_t kt;
        begin
            unique case (num)
                5'd2:    kt = KT_INTEGER;
                5'd3:    kt = KT_BITSTRING;
                5'd4:    kt = KT_OCTETSTR;
                5'd5:    kt = KT_NULL;
                5'd6:    kt = KT_OID;
                5'd10:   kt = KT_ENUM;
                5'd12:   kt = KT_UTF8;
                5'd16:   kt = KT_SEQUENCE;
                5'd17:   kt = KT_SET;
                5'd18:   kt = KT_NUMERIC;
                5'd19:   kt = KT_PRINTABLE;
                5'd22:   kt = KT_IA5;
                5'd23:   kt = KT_UTCTIME;
                5'd24:   kt = KT_GENTIME;
                default: kt = KT_UNKNOWN;
            endcase
            return kt;
        end
    endfunction

endpackage

### rtl/core/btlv_fsm.sv
// Header byte sequencer: tag, length and long-form length bytes.
// Depends on btlv_pkg; produces an emit request for btlv_result.
module btlv_fsm #(
    parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF,
    parameter int AVAIL_WIDTH      = btlv_pkg::AVAIL_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [btlv_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             frame_start,
    input  logic [btlv_pkg::AVAIL_IN_W-1:0]  bytes_available,
    output btlv_pkg::emit_req_t              req,
    output logic [AVAIL_WIDTH-1:0]           avail
);
    import btlv_pkg::*;

    localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int KEEP_W = (AVAIL_WIDTH < AVAIL_IN_W) ? AVAIL_WIDTH : AVAIL_IN_W;

    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    tag_reg, tag_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic [LEFT_W-1:0]    total_reg, total_next;
    logic [LEN_W-1:0]     acc_reg, acc_next;
    logic [AVAIL_WIDTH-1:0] avail_reg, avail_next;

    logic [AVAIL_WIDTH-1:0] avail_in;
    logic [6:0]             cnt;
    logic [HSIZE_W-1:0]     long_hsize;
    logic [LEN_W-1:0]       acc_shift;
    logic [LEFT_W-1:0]      left_dec;

    assign avail_in   = AVAIL_WIDTH'(bytes_available[KEEP_W-1:0]);
    assign cnt        = data_byte[6:0];
    assign long_hsize = HSIZE_W'(cnt) + HSIZE_W'(2);
    assign acc_shift  = {acc_reg[LEN_W-BYTE_W-1:0], data_byte};
    assign left_dec   = (left_reg != '0) ? left_reg - LEFT_W'(1) : left_reg;

    // Next state and emit request for the byte in the input register
    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        left_next  = left_reg;
        total_next = total_reg;
        acc_next   = acc_reg;
        avail_next = avail_reg;
        req.emit   = 1'b0;
        req.indef  = 1'b0;
        req.len    = '0;
        req.hsize  = '0;
        req.forced = ST_OK;

        if (frame_start)
        begin
            tag_next   = data_byte;
            avail_next = avail_in;
            left_next  = '0;
            total_next = '0;
            acc_next   = '0;
            if (avail_in < AVAIL_WIDTH'(2))
            begin
                req.emit   = 1'b1;
                req.hsize  = HSIZE_W'(1);
                req.forced = ST_SHORT;
                phase_next = PH_IDLE;
            end
            else
            begin
                phase_next = PH_LEN;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    phase_next = PH_IDLE;
                    left_next  = '0;
                    req.emit   = 1'b1;
                    if (!data_byte[7])
                    begin
                        req.len   = LEN_W'(data_byte);
                        req.hsize = HSIZE_W'(2);
                    end
                    else if (data_byte == LEN_INDEFINITE)
                    begin
                        req.indef = 1'b1;
                        req.len   = LEN_W'(avail_reg) - LEN_W'(2);
                        req.hsize = HSIZE_W'(2);
                    end
                    else if (cnt > 7'(MAX_LENGTH_BYTES))
                    begin
                        req.hsize  = long_hsize;
                        req.forced = ST_LEN_LONG;
                    end
                    else if (AVAIL_WIDTH'(long_hsize) > avail_reg)
                    begin
                        req.hsize  = long_hsize;
                        req.forced = ST_SHORT;
                    end
                    else
                    begin
                        // Gather the long-form length bytes next
                        req.emit   = 1'b0;
                        phase_next = PH_LONG;
                        total_next = cnt[LEFT_W-1:0];
                        left_next  = cnt[LEFT_W-1:0];
                        acc_next   = '0;
                    end
                end
                PH_LONG:
                begin
                    acc_next  = acc_shift;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        req.emit   = 1'b1;
                        req.len    = acc_shift;
                        req.hsize  = HSIZE_W'(total_reg) + HSIZE_W'(2);
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        req.tag_byte = tag_next;
    end

    assign avail = avail_next;

    // Advance the state only when the input beat is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tag_reg   <= '0;
            left_reg  <= '0;
            total_reg <= '0;
            acc_reg   <= '0;
            avail_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            acc_reg   <= acc_next;
            avail_reg <= avail_next;
        end
    end

endmodule

### rtl/core/btlv_result.sv
// Result builder: tag fields, known-tag lookup and status checks.
// Depends on btlv_pkg; purely combinational, fed by btlv_fsm.
module btlv_result #(
    parameter int AVAIL_WIDTH = btlv_pkg::AVAIL_WIDTH_DEF
) (
    input  btlv_pkg::emit_req_t        req,
    input  logic [AVAIL_WIDTH-1:0]     avail,
    output btlv_pkg::result_t          res
);
    import btlv_pkg::*;

    known_tag_t         known;
    logic [1:0]         cls;
    logic               empty_bad;
    logic [LEN_W:0]     span;
    logic               exceeds;

    assign cls   = req.tag_byte[7:6];
    assign known = known_map(req.tag_byte[4:0]);

    // Empty content is fine for NULL, SEQUENCE, SET and unknown context tags
    assign empty_bad = (req.len == '0) && (known != KT_NULL) && (known != KT_SEQUENCE)
                       && (known != KT_SET) && !((cls == CLS_CONTEXT) && (known == KT_UNKNOWN));

    // Header plus content must fit in the bytes available
    assign span    = {1'b0, req.len} + (LEN_W+1)'(req.hsize);
    assign exceeds = span > (LEN_W+1)'(avail);

    always_comb
    begin
        res.tag_class      = cls;
        res.is_constructed = req.tag_byte[5];
        res.tag_number     = req.tag_byte[4:0];
        res.known_tag      = known;
        res.indefinite     = req.indef;
        res.body_len       = req.len;
        res.header_size    = req.hsize;
        if (req.forced != ST_OK)
            res.status = req.forced;
        else if (empty_bad)
            res.status = ST_EMPTY;
        else if (exceeds)
            res.status = ST_EXCEEDS;
        else
            res.status = ST_OK;
    end

endmodule

### rtl/core/ber_tlv_header_parser_core.sv
// Top level of the BER TLV header parser: input and output registers.
// Depends on btlv_pkg, btlv_fsm and btlv_result.
//
// Usage:
//   Slave stream carries one header byte per beat. s_tuser marks the tag
//   byte of a new header (it aborts any header in progress) and
//   bytes_available in s_tdata is sampled with that tag byte.
//   Master stream carries one decoded header per beat, sent after the last
//   header byte (tag byte alone when fewer than two bytes are available,
//   the length byte for short, indefinite or rejected long forms, else the
//   last long-form length byte). Other bytes produce no beat.
// Path: the last header byte is held in the input register, then decoded into
//   the output register, whose valid flag drives m_tvalid.
// Throughput: one byte per cycle while no held result blocks it, set by the
//   single decode stage between the input register and the output register.
// Reset: rst_n clears both registers' valid flags and returns the decoder
//   to waiting for a tag byte.
// Stall: while m_tready is low a held result blocks only a byte that
//   would produce another result; s_tready drops until the beat leaves.
module ber_tlv_header_parser_core #(
    parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF,
    parameter int AVAIL_WIDTH      = btlv_pkg::AVAIL_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] data_byte, [39:8] bytes_available
    input  logic [39:0]                       s_tdata,
    // [0] frame_start
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] tag_class, [2] is_constructed, [7:3] tag_number, [11:8] known_tag,
    // [12] indefinite, [76:13] body_len, [84:77] header_size, [87:85] status
    output logic [btlv_pkg::RESULT_W-1:0]     m_tdata
);
    import btlv_pkg::*;

    logic                   in_valid_reg;
    logic [BYTE_W-1:0]      byte_reg;
    logic                   start_reg;
    logic [AVAIL_IN_W-1:0]  avail_in_reg;

    logic                   out_valid_reg;
    result_t                result_reg;

    emit_req_t              req;
    logic [AVAIL_WIDTH-1:0] avail;
    result_t                res;
    logic                   out_free;
    logic                   advance;

    // Consume the held byte unless its result has nowhere to go
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!req.emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg     <= s_tdata[7:0];
            avail_in_reg <= s_tdata[39:8];
            start_reg    <= s_tuser;
        end
    end

    btlv_fsm #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .AVAIL_WIDTH      (AVAIL_WIDTH)
    ) u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .data_byte       (byte_reg),
        .frame_start     (start_reg),
        .bytes_available (avail_in_reg),
        .req             (req),
        .avail           (avail)
    );

    btlv_result #(
        .AVAIL_WIDTH (AVAIL_WIDTH)
    ) u_result (
        .req   (req),
        .avail (avail),
        .res   (res)
    );

    // Output register: load a new result, drop a taken one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && req.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && req.emit)
            result_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule
